### rtl/dedup_subscriber_table_top_macros.svh
// Assertion macros for the subscriber table checker.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef DEDUP_SUBSCRIBER_TABLE_TOP_MACROS_SVH
`define DEDUP_SUBSCRIBER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define DST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("subscriber table check failed");

// Next-cycle implication, disabled while in reset
`define DST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("subscriber table check failed");

`endif

### rtl/dst_pkg.sv
// Shared types, codes and defaults for the subscriber table.
// No dependencies; the top level and the checker import it.
package dst_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BYTES_DEF   = 16;
  localparam int CAP_W           = 5;
  localparam int LEN_W           = 5;
  localparam int TOTAL_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             command;
    logic [63:0]      key_low;
    logic [63:0]      key_high;
    logic [LEN_W-1:0] key_length;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic [TOTAL_W-1:0] entry_total;
  } out_beat_t;

endpackage

### rtl/dedup_subscriber_table_top.sv
// Top level of the deduplicating subscriber table.
// Uses dst_pkg and dst_key_cmp; entries live in one synchronous memory.
//
//  channel | ports                               | accepted when
//  input   | in_valid, in_stall, in_data         | in_valid && !in_stall
//  result  | out_valid, out_stall, out_data      | out_valid && !out_stall
//  config  | cfg_we, cfg_wdata (capacity)        | cfg_we
//
// One command at a time: a full add goes straight to loading its result; else the
// scan reads one entry a cycle, a remove that finds its key then shifts later entries
// down one place, and the result is loaded last.
// Reset empties the table at once; no clearing pass.
// A stalled result holds in the output register while the next command is taken.
module dedup_subscriber_table_top #(
  parameter int TABLE_DEPTH = dst_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = dst_pkg::KEY_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  dst_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output dst_pkg::out_beat_t       out_data,
  input  logic                     cfg_we,
  input  logic [dst_pkg::CAP_W-1:0] cfg_wdata
);

  import dst_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int EW = LEN_W + KW;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MW = CW + CAP_W;

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_vld_r, out_vld_nxt;
  logic             pend_r, pend_nxt;

  // Working registers for the current command
  logic             cmd_r, cmd_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    pidx_r, pidx_nxt;
  logic [IW-1:0]    at_r, at_nxt;
  logic             found_r, found_nxt;
  status_t          st_r, st_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  // Memory port
  logic [EW-1:0]    mem [TABLE_DEPTH];
  logic [EW-1:0]    rdata_r;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;

  // Derived conditions
  logic             in_acc;
  logic             tbl_full;
  logic [MW-1:0]    eff_cap;
  logic             issue;
  logic             walk_end;
  logic             key_eq;
  logic             hit;
  logic [KW-1:0]    in_key;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign in_key    = KW'({in_data.key_high, in_data.key_low});

  // Effective capacity is the smaller of the register and the depth
  assign eff_cap  = (MW'(cap_r) < MW'(TABLE_DEPTH)) ? MW'(cap_r) : MW'(TABLE_DEPTH);
  assign tbl_full = MW'(cnt_r) >= eff_cap;

  assign issue    = idx_r < cnt_r;
  assign walk_end = !issue && !pend_r;
  assign rd_addr  = idx_r[IW-1:0];

  dst_key_cmp #(
    .KEY_BYTES(KEY_BYTES)
  ) u_cmp (
    .key_a(rdata_r[KW-1:0]),
    .key_b(key_r),
    .equal(key_eq)
  );

  // Add matches on length and key; remove on key alone
  assign hit = pend_r && key_eq &&
               ((cmd_r == CMD_REMOVE) || (rdata_r[EW-1:KW] == len_r));

  // Write and read the entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.command == CMD_ADD && tbl_full) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ADD && hit) begin
          state_nxt = S_DONE;
        end else if (walk_end) begin
          state_nxt = (cmd_r == CMD_REMOVE && found_r) ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (walk_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    at_nxt       = at_r;
    found_nxt    = found_r;
    st_nxt       = st_r;
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r;
    pend_nxt     = 1'b0;
    mem_we       = 1'b0;
    wr_addr      = cnt_r[IW-1:0];
    wr_data      = {len_r, key_r};

    // Drop the result once taken
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_data.command;
          key_nxt   = in_key;
          len_nxt   = in_data.key_length;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          st_nxt    = ST_FULL;
        end
      end
      S_SCAN: begin
        // Advance the read pointer, one entry a beat
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IW-1:0];
        end
        if (hit) begin
          if (cmd_r == CMD_ADD) begin
            st_nxt   = ST_DUPLICATE;
            pend_nxt = 1'b0;
          end else begin
            found_nxt = 1'b1;
            at_nxt    = pidx_r;
          end
        end
        if (walk_end) begin
          if (cmd_r == CMD_ADD) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            st_nxt  = ST_ADDED;
          end else if (found_r) begin
            idx_nxt = CW'(at_r) + CW'(1);
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        // Read entry i+1, write it back at i on the next beat
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IW-1:0];
        end
        if (pend_r) begin
          mem_we  = 1'b1;
          wr_addr = pidx_r - IW'(1);
          wr_data = rdata_r;
        end
        if (walk_end) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = ST_REMOVED;
        end
      end
      S_DONE: begin
        if (!out_vld_r || !out_stall) begin
          out_data_nxt.status      = st_r;
          out_data_nxt.entry_total = TOTAL_W'(cnt_r);
          out_vld_nxt              = 1'b1;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cap_r     <= CAP_RESET;
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      pend_r    <= pend_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    at_r       <= at_nxt;
    found_r    <= found_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/dst_key_cmp.sv
// Key comparator: bytewise match that stops at the first byte zero in both keys.
// Depends on nothing but its parameter.
module dst_key_cmp #(
  parameter int KEY_BYTES = 16
) (
  input  logic [8*KEY_BYTES-1:0] key_a,
  input  logic [8*KEY_BYTES-1:0] key_b,
  output logic                   equal
);

  logic [KEY_BYTES-1:0] byte_eq;
  logic [KEY_BYTES-1:0] byte_end;

  // Flag each byte: equal, and equal and zero (terminator)
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      byte_eq[i]  = key_a[8*i +: 8] == key_b[8*i +: 8];
      byte_end[i] = byte_eq[i] && (key_a[8*i +: 8] == 8'd0);
    end
  end

  // A byte counts only if no shared terminator came before it
  always_comb begin
    logic stopped;
    stopped = 1'b0;
    equal   = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!stopped && !byte_eq[i]) begin
        equal = 1'b0;
      end
      stopped = stopped | byte_end[i];
    end
  end

endmodule

### rtl/dst_checker.sv
// Port-level checks for the subscriber table, bound to the top level.
// Uses dst_pkg and the macros header.
`include "dedup_subscriber_table_top_macros.svh"

module dst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dst_pkg::out_beat_t out_data
);

  import dst_pkg::*;

  // A stalled result beat holds
  `DST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // An accepted command keeps the input busy for the next cycle
  `DST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // No result appears the cycle right after a command is taken, if no older result stalls
  `DST_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && (!out_valid || !out_stall),
                   !out_valid)

  // Added or duplicate implies at least one entry remains
  `DST_ASSERT_NOW(a_total_nonzero,
                  out_valid && (out_data.status == ST_ADDED || out_data.status == ST_DUPLICATE),
                  out_data.entry_total != '0)

endmodule

bind dedup_subscriber_table_top dst_checker u_dst_checker (.*);
